### hw/rtl/rmst_pkg.sv
// Shared types, constants and helpers for the range-minimum segment tree.
`timescale 1ns / 1ps
`default_nettype none

package rmst_pkg;

   // Field widths of the request and response beats
   localparam int unsigned VAL_W   = 47;
   localparam int unsigned FIRST_W = 10;
   localparam int unsigned END_W   = 11;

   // Default leaf count
   localparam int unsigned LEAVES_DEFAULT = 1024;

   // Value of an empty node and of an empty query
   localparam logic [VAL_W-1:0] SENTINEL = 47'd100000000000000;

   // Request opcodes
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_W_LEAF,
      ST_W_UP,
      ST_Q_WALK,
      ST_Q_DONE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic clr_step;   // write one node of the initial image
      logic load;       // capture the request beat
      logic w_leaf;     // write the leaf, read its sibling
      logic w_up;       // write one ancestor, read the next sibling
      logic q_walk;     // one level of the range cover
      logic rsp_load;   // move the minimum into the response register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic clr_last;   // last node of the initial image
      logic req_write;  // pending request beat is a write
      logic req_skip;   // write addresses a leaf past the tree
      logic w_root;     // ancestor being written is the root
      logic q_active;   // range cover not yet finished
   } sts_type;

   // Unsigned minimum of two node values
   function automatic logic [VAL_W-1:0] min_val(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rmst_ctrl.sv
// Controller state machine of the range-minimum segment tree.
`timescale 1ns / 1ps
`default_nettype none

module rmst_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire rmst_pkg::sts_type sts,
   output rmst_pkg::cmd_type     cmd
);

   rmst_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // State and response-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmst_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = rmst_pkg::ST_IDLE;
            end
         end
         rmst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               priority if (sts.req_write && sts.req_skip) begin
                  state_in = rmst_pkg::ST_IDLE;
               end else if (sts.req_write) begin
                  state_in = rmst_pkg::ST_W_LEAF;
               end else begin
                  state_in = rmst_pkg::ST_Q_WALK;
               end
            end
         end
         rmst_pkg::ST_W_LEAF: begin
            cmd.w_leaf = 1'b1;
            state_in   = rmst_pkg::ST_W_UP;
         end
         rmst_pkg::ST_W_UP: begin
            cmd.w_up = 1'b1;
            if (sts.w_root) begin
               state_in = rmst_pkg::ST_IDLE;
            end
         end
         rmst_pkg::ST_Q_WALK: begin
            cmd.q_walk = 1'b1;
            if (!sts.q_active) begin
               state_in = rmst_pkg::ST_Q_DONE;
            end
         end
         rmst_pkg::ST_Q_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = rmst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmst_pkg::ST_CLEAR;
         end
      endcase
   end

   // Set on a new result, drop when the beat is taken
   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### hw/rtl/rmst_dp.sv
// Datapath of the range-minimum segment tree: node memory, walk indices, minima.
`timescale 1ns / 1ps
`default_nettype none

module rmst_dp #(
   parameter int unsigned LEAVES = rmst_pkg::LEAVES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_op,
   input  wire logic [rmst_pkg::FIRST_W-1:0] req_first_index,
   input  wire logic [rmst_pkg::END_W-1:0]   req_end_index,
   input  wire logic [rmst_pkg::VAL_W-1:0]   req_value,
   input  wire rmst_pkg::cmd_type            cmd,
   output rmst_pkg::sts_type                 sts,
   output logic [rmst_pkg::VAL_W-1:0]        rsp_min_value
);

   localparam int unsigned LOG_P = $clog2(LEAVES);
   localparam int unsigned P     = 1 << LOG_P;
   localparam int unsigned NODES = 2 * P;
   localparam int unsigned NW    = LOG_P + 1;
   localparam int unsigned EW    = ((NW > rmst_pkg::END_W) ? NW : rmst_pkg::END_W) + 1;

   typedef logic [rmst_pkg::VAL_W-1:0] val_type;

   // Node memory, 1-based: root at 1, leaf k at P+k
   val_type mem [0:NODES-1];

   logic [NW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NW-1:0] node_ff, node_in;
   logic [NW:0]   l_ff, l_in, r_ff, r_in;
   val_type       cur_ff, cur_in;
   val_type       res_ff, res_in;
   val_type       rsp_ff, rsp_in;
   val_type       rd_a_ff, rd_b_ff;
   logic          fa_ff, fa_in, fb_ff, fb_in;

   logic          mem_we;
   logic [NW-1:0] mem_waddr;
   val_type       mem_wdata;
   logic [NW-1:0] rd_addr_a, rd_addr_b;
   logic [NW-1:0] par;
   logic [NW:0]   r_dec;
   logic [EW-1:0] a_ext, b_ext, p_ext, b_clamp, a_sum, r_sum;
   logic          q_empty;
   logic          clr_pow2;
   val_type       up_min, a_val, b_val;
   logic          res_lt_a, res_lt_b, a_lt_b;

   // Decode the request beat
   always_comb begin
      a_ext   = EW'(req_first_index);
      b_ext   = EW'(req_end_index);
      p_ext   = EW'(P);
      b_clamp = (b_ext > p_ext) ? p_ext : b_ext;
      q_empty = (a_ext >= b_clamp);
      a_sum   = a_ext + p_ext;
      r_sum   = b_clamp + p_ext;
   end

   assign par      = node_ff >> 1;
   assign r_dec    = r_ff - (NW + 1)'(1);
   assign up_min   = rmst_pkg::min_val(cur_ff, rd_a_ff);
   assign clr_pow2 = (clr_cnt_ff != '0) && ((clr_cnt_ff & (clr_cnt_ff - NW'(1))) == '0);

   // Status
   always_comb begin
      sts           = '0;
      sts.clr_last  = (clr_cnt_ff == NW'(NODES - 1));
      sts.req_write = (rmst_pkg::op_type'(req_op) == rmst_pkg::OP_WRITE);
      sts.req_skip  = (a_ext >= p_ext);
      sts.w_root    = (par == NW'(1));
      sts.q_active  = (l_ff < r_ff);
   end

   // Memory write and read addresses
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = rmst_pkg::SENTINEL;
      rd_addr_a = l_ff[NW-1:0];
      priority if (cmd.clr_step) begin
         mem_we    = 1'b1;
         mem_wdata = clr_pow2 ? '0 : rmst_pkg::SENTINEL;
      end else if (cmd.w_leaf) begin
         mem_we    = 1'b1;
         mem_waddr = node_ff;
         mem_wdata = cur_ff;
         rd_addr_a = node_ff ^ NW'(1);
      end else if (cmd.w_up) begin
         mem_we    = 1'b1;
         mem_waddr = par;
         mem_wdata = up_min;
         rd_addr_a = par ^ NW'(1);
      end else begin
         mem_we = 1'b0;
      end
      rd_addr_b = r_dec[NW-1:0];
   end

   // Node memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   // Fold the nodes addressed in the previous cycle into the running minimum
   always_comb begin
      a_val    = fa_ff ? rd_a_ff : rmst_pkg::SENTINEL;
      b_val    = fb_ff ? rd_b_ff : rmst_pkg::SENTINEL;
      res_lt_a = (res_ff < a_val);
      res_lt_b = (res_ff < b_val);
      a_lt_b   = (a_val < b_val);
      priority if (res_lt_a && res_lt_b) begin
         res_in = res_ff;
      end else if (a_lt_b) begin
         res_in = a_val;
      end else begin
         res_in = b_val;
      end
   end

   // Next values of the walk registers
   always_comb begin
      clr_cnt_in = cmd.clr_step ? clr_cnt_ff + NW'(1) : clr_cnt_ff;
      node_in    = node_ff;
      cur_in     = cur_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      fa_in      = 1'b0;
      fb_in      = 1'b0;
      rsp_in     = cmd.rsp_load ? res_ff : rsp_ff;
      priority if (cmd.load) begin
         cur_in  = req_value;
         node_in = a_sum[NW-1:0];
         l_in    = q_empty ? '0 : a_sum[NW:0];
         r_in    = q_empty ? '0 : r_sum[NW:0];
      end else if (cmd.w_up) begin
         node_in = par;
         cur_in  = up_min;
      end else if (cmd.q_walk && sts.q_active) begin
         // read the odd boundary nodes, then climb one level
         fa_in = l_ff[0];
         fb_in = r_ff[0];
         l_in  = (l_ff + (NW + 1)'(l_ff[0])) >> 1;
         r_in  = (r_ff - (NW + 1)'(r_ff[0])) >> 1;
      end else begin
         node_in = node_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         fa_ff      <= 1'b0;
         fb_ff      <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         fa_ff      <= fa_in;
         fb_ff      <= fb_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      node_ff <= node_in;
      cur_ff  <= cur_in;
      l_ff    <= l_in;
      r_ff    <= r_in;
      res_ff  <= cmd.load ? rmst_pkg::SENTINEL : res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_min_value = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/range_min_segment_tree_top.sv
// Top level of the range-minimum segment tree.
//
//   Channel  Ports                                        Direction  Beat
//   req      req_valid/ready, op, first_index, end_index  in         write or query
//            value
//   rsp      rsp_valid/ready, min_value                   out        one per query
//
// A write stores the leaf, then one ancestor per cycle on a single write port,
// up to the root. The tree has P leaves: LEAVES rounded up to a power of two.
// A query climbs one tree level per cycle, reading both boundary nodes on two
// read ports; the registered reads are then folded into the minimum, and the
// result moves to the output register once that register is free.
// After reset a clearing pass writes the initial tree image, during which
// req_ready is low. One item is in work at a time; a finished result waits in
// the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module range_min_segment_tree_top #(
   parameter int unsigned LEAVES = rmst_pkg::LEAVES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_op,
   input  wire logic [rmst_pkg::FIRST_W-1:0] req_first_index,
   input  wire logic [rmst_pkg::END_W-1:0]   req_end_index,
   input  wire logic [rmst_pkg::VAL_W-1:0]   req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [rmst_pkg::VAL_W-1:0]        rsp_min_value
);

   rmst_pkg::cmd_type cmd;
   rmst_pkg::sts_type sts;

   // Sequence the clearing pass, writes and queries
   rmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Node memory and walk arithmetic
   rmst_dp #(
      .LEAVES (LEAVES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_first_index (req_first_index),
      .req_end_index   (req_end_index),
      .req_value       (req_value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_min_value   (rsp_min_value)
   );

endmodule

`default_nettype wire

### hw/rtl/rmst_chk.sv
// Port-level checks for the range-minimum segment tree, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rmst_chk (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         req_op,
   input wire logic [rmst_pkg::FIRST_W-1:0] req_first_index,
   input wire logic [rmst_pkg::END_W-1:0]   req_end_index,
   input wire logic [rmst_pkg::VAL_W-1:0]   req_value,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [rmst_pkg::VAL_W-1:0]   rsp_min_value
);

   // Reset leaves nothing to deliver and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!req_ready && !rsp_valid))
      else $error("req_ready or rsp_valid high right after reset");

   // A stalled response beat holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_min_value)))
      else $error("stalled response beat changed");

   // A query keeps the block busy in the cycle after it is accepted
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_op == rmst_pkg::OP_QUERY)) |=> !req_ready)
      else $error("request taken right after a query");

   // A write never produces a response beat
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_op == rmst_pkg::OP_WRITE) && !rsp_valid)
      |=> !rsp_valid)
      else $error("response beat after a write");

   // A new response appears only after the block was busy
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response beat without a query in work");

endmodule

bind range_min_segment_tree_top rmst_chk u_rmst_chk (.*);

`default_nettype wire
